[rtl/laplacian_sharpen_3x3_macros.svh]
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_macros
// assertion shorthands shared by the sharpening filter rtl
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_SHARPEN_3X3_MACROS_SVH
`define LAPLACIAN_SHARPEN_3X3_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lps check failed: same-cycle rule");

// next-cycle implication, checked out of reset
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lps check failed: next-cycle rule");

`endif

[rtl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// shared types and constants of the 3x3 laplacian sharpening filter
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int SampleW   = 8;
  localparam int ConfigW   = 11;
  localparam int ChanW     = 3;
  localparam int RowW      = 10;
  localparam int StoreAw   = 12;
  localparam int StoreDepth = 4096;
  localparam int CfgIdxW   = 2;

  localparam int MinDim    = 3;
  localparam int MaxHeight = 1024;

  localparam logic [ConfigW-1:0] WidthReset    = 11'd640;
  localparam logic [ConfigW-1:0] HeightReset   = 11'd480;
  localparam logic [ChanW-1:0]   ChannelsReset = 3'd3;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } lps_cfg_e;

  // per-word flags carried from the input register to the result side
  typedef struct packed {
    logic need_first;   // word yields the delayed result of the row above
    logic interior;     // delayed result is a filtered sample, not border
    logic need_border;  // word sits in the last row: its own zero sample
    logic last_frame;   // border sample closes the frame
    logic parity;       // row parity, picks the bank roles
  } lps_item_t;

endpackage

[rtl/lps_ram.sv]
// ----------------------------------------------------------------------------
// lps_ram
// generic one-write two-read ram with registered, read-first outputs
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[rtl/lps_kernel.sv]
// ----------------------------------------------------------------------------
// lps_kernel
// five-point laplacian sharpening sum with clamp to the sample range
// ----------------------------------------------------------------------------
module lps_kernel
  import lps_pkg::*;
(
  input  logic [SampleW-1:0] centre_i,
  input  logic [SampleW-1:0] left_i,
  input  logic [SampleW-1:0] right_i,
  input  logic [SampleW-1:0] up_i,
  input  logic [SampleW-1:0] down_i,
  output logic [SampleW-1:0] value_o
);

  logic [11:0]        gain;
  logic [11:0]        neigh;
  logic signed [11:0] diff;

  always_comb begin
    // 5 * centre as shift plus add
    gain  = {2'b00, centre_i, 2'b00} + {4'b0000, centre_i};
    neigh = {4'b0000, left_i} + {4'b0000, right_i} + {4'b0000, up_i}
          + {4'b0000, down_i};
    diff  = $signed(gain) - $signed(neigh);
    if (diff < 12'sd0) begin
      value_o = '0;
    end else if (diff > 12'sd255) begin
      value_o = '1;
    end else begin
      value_o = diff[SampleW-1:0];
    end
  end

endmodule

[rtl/laplacian_sharpen_3x3.sv]
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// 3x3 laplacian sharpening filter over a raster stream of interleaved samples
// ----------------------------------------------------------------------------
// The filter takes one channel sample per word in raster order and returns,
// for each sample of the row above, clamp(5*centre - left - right - up - down)
// to 0..255, with left and right the same channel one pixel away; first and
// last rows and columns come out as 0. Results lag the input by one row; in
// the last row each input word also yields its own zero border word, and the
// final one carries last_of_frame. One input word is taken per clock unless
// the result side stalls; a last-row word sends two words on the single
// result port and holds the input meanwhile. The ram read and the word
// register take the accepting edge, the result register loads when the port
// is free. The two line stores are 4096 x 8 rams with one write and two
// read ports, used by row parity; they are never cleared. Users must write
// configuration only while the filter holds no pending words; not enforced.
// ----------------------------------------------------------------------------
`include "laplacian_sharpen_3x3_macros.svh"

module laplacian_sharpen_3x3
  import lps_pkg::*;
#(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ConfigW-1:0] cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               start_of_frame_i,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SampleW-1:0] pixel_value_o,
  output logic               last_of_frame_o
);

  // row length reaches MAX_WIDTH * MAX_CHANNELS; compare at least one bit
  // above the store address so that position + 1 never wraps
  localparam int LenW    = $clog2(MAX_WIDTH * MAX_CHANNELS + 1);
  localparam int CW      = (LenW > StoreAw + 1) ? LenW : StoreAw + 1;
  localparam int HistAw  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // configuration registers
  logic [ConfigW-1:0] cfg_width_q;
  logic [ConfigW-1:0] cfg_height_q;
  logic [ChanW-1:0]   cfg_chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_chan_q   <= ChannelsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   cfg_width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT:  cfg_height_q <= cfg_wdata_i;
        CFG_CHANNEL_COUNT: cfg_chan_q   <= cfg_wdata_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW-1:0]      width_c;
  logic [ConfigW-1:0] height_c;
  logic [ChanW-1:0]   chan_c;
  logic [CW-1:0]      row_len;
  logic [CW-1:0]      inner_end;   // first sample position of the last column

  always_comb begin
    if (CW'(cfg_width_q) < CW'(MinDim)) begin
      width_c = CW'(MinDim);
    end else if (CW'(cfg_width_q) > CW'(MAX_WIDTH)) begin
      width_c = CW'(MAX_WIDTH);
    end else begin
      width_c = CW'(cfg_width_q);
    end
    if (cfg_height_q < ConfigW'(MinDim)) begin
      height_c = ConfigW'(MinDim);
    end else if (cfg_height_q > ConfigW'(MaxHeight)) begin
      height_c = ConfigW'(MaxHeight);
    end else begin
      height_c = cfg_height_q;
    end
    if (cfg_chan_q == '0) begin
      chan_c = ChanW'(1);
    end else if (cfg_chan_q > ChanW'(MAX_CHANNELS)) begin
      chan_c = ChanW'(MAX_CHANNELS);
    end else begin
      chan_c = cfg_chan_q;
    end
    row_len   = CW'(width_c * CW'(chan_c));
    inner_end = CW'((width_c - CW'(1)) * CW'(chan_c));
  end

  // ---------------------------------------------------------------------------
  // input side: position counters, ram addressing, flags for the word
  // ---------------------------------------------------------------------------
  logic               in_accept;
  logic               s1_retire;
  logic [RowW-1:0]    row_q, row_d;
  logic [StoreAw-1:0] samp_q, samp_d;
  logic [RowW-1:0]    row_eff;
  logic [StoreAw-1:0] samp_eff;
  logic [ConfigW-1:0] row_ext;
  logic [ConfigW-1:0] row_inc;
  logic [StoreAw:0]   samp_inc;
  logic               row_end;
  lps_item_t          item_d;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    // a start mark restarts the positions for this very word
    row_eff  = start_of_frame_i ? '0 : row_q;
    samp_eff = start_of_frame_i ? '0 : samp_q;
    row_ext  = ConfigW'(row_eff);
    row_inc  = row_ext + ConfigW'(1);
    samp_inc = {1'b0, samp_eff} + (StoreAw+1)'(1);
    row_end  = CW'(samp_inc) >= row_len;

    item_d.need_first  = row_eff != '0;
    // delayed row must be neither the first row nor at or past the last
    item_d.interior    = (row_ext >= ConfigW'(2)) && (row_ext < height_c)
                       && (CW'(samp_eff) >= CW'(chan_c))
                       && (CW'(samp_eff) < inner_end);
    item_d.need_border = row_ext >= (height_c - ConfigW'(1));
    item_d.last_frame  = row_end;
    item_d.parity      = row_eff[0];

    if (row_end) begin
      samp_d = '0;
      row_d  = (row_inc >= height_c) ? '0 : row_inc[RowW-1:0];
    end else begin
      samp_d = samp_inc[StoreAw-1:0];
      row_d  = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      samp_q <= '0;
    end else if (in_accept) begin
      row_q  <= row_d;
      samp_q <= samp_d;
    end
  end

  // line stores: even rows in bank 0, odd rows in bank 1; port a reads the
  // word's own position (up or centre), port b the right-hand neighbor
  logic [StoreAw-1:0] addr_right;
  logic [SampleW-1:0] bank0_a, bank0_b, bank1_a, bank1_b;

  assign addr_right = samp_eff + StoreAw'(chan_c);

  lps_ram #(
    .Width (SampleW),
    .Depth (StoreDepth)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (in_accept && !row_eff[0]),
    .waddr_i   (samp_eff),
    .wdata_i   (sample_i),
    .re_i      (in_accept),
    .raddr_a_i (samp_eff),
    .raddr_b_i (addr_right),
    .rdata_a_o (bank0_a),
    .rdata_b_o (bank0_b)
  );

  lps_ram #(
    .Width (SampleW),
    .Depth (StoreDepth)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (in_accept && row_eff[0]),
    .waddr_i   (samp_eff),
    .wdata_i   (sample_i),
    .re_i      (in_accept),
    .raddr_a_i (samp_eff),
    .raddr_b_i (addr_right),
    .rdata_a_o (bank1_a),
    .rdata_b_o (bank1_b)
  );

  // ---------------------------------------------------------------------------
  // word register, aligned with the registered ram data
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_sent_q;     // delayed result already handed on
  lps_item_t          s1_item_q;
  logic [SampleW-1:0] s1_down_q;
  logic [HistAw-1:0]  s1_left_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_retire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q     <= item_d;
      s1_down_q     <= sample_i;
      s1_left_sel_q <= HistAw'(chan_c - ChanW'(1));
    end
  end

  // centre samples of the previous words of this row, newest first; the
  // left neighbor sits one pixel, i.e. channel-count words, back
  logic [SampleW-1:0] centre, up, right, left, filtered;
  logic [SampleW-1:0] hist_q [MAX_CHANNELS];

  always_comb begin
    // even row: bank 0 is the row being written, bank 1 the row above
    if (!s1_item_q.parity) begin
      centre = bank1_a;
      right  = bank1_b;
      up     = bank0_a;
    end else begin
      centre = bank0_a;
      right  = bank0_b;
      up     = bank1_a;
    end
    left = hist_q[s1_left_sel_q];
  end

  always_ff @(posedge clk_i) begin
    if (s1_retire) begin
      hist_q[0] <= centre;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  lps_kernel u_kernel (
    .centre_i (centre),
    .left_i   (left),
    .right_i  (right),
    .up_i     (up),
    .down_i   (s1_down_q),
    .value_o  (filtered)
  );

  // ---------------------------------------------------------------------------
  // result register: up to two words per input word, unless the result side stalls one per clock
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic [SampleW-1:0] out_pixel_q;
  logic               out_lof_q;
  logic               first_due;
  logic               any_due;
  logic               one_left;
  logic               out_load;

  always_comb begin
    first_due = s1_item_q.need_first && !s1_sent_q;
    any_due   = first_due || s1_item_q.need_border;
    one_left  = !(first_due && s1_item_q.need_border);
    out_load  = s1_valid_q && any_due && (!out_valid_q || !out_stall_i);
    // a word with nothing to send leaves at once
    s1_retire = s1_valid_q && (!any_due || (out_load && one_left));
  end

  assign in_stall_o = s1_valid_q && !s1_retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_sent_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_retire) begin
        s1_sent_q <= 1'b0;
      end else if (out_load && first_due) begin
        s1_sent_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (first_due) begin
        out_pixel_q <= s1_item_q.interior ? filtered : '0;
        out_lof_q   <= 1'b0;
      end else begin
        out_pixel_q <= '0;
        out_lof_q   <= s1_item_q.last_frame;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_value_o   = out_pixel_q;
  assign last_of_frame_o = out_lof_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // frame end is only ever flagged on a border word
  `LPS_ASSERT_NOW(a_lof_is_border, clk_i, rst_ni, out_valid_o && last_of_frame_o, pixel_value_o == '0)
  // the delayed result is marked sent only while the border word still waits
  `LPS_ASSERT_NOW(a_sent_needs_border, clk_i, rst_ni, s1_sent_q, s1_valid_q && s1_item_q.need_border)
  // a retired word with no new one behind it leaves the register empty
  `LPS_ASSERT_NEXT(a_retire_empties, clk_i, rst_ni, s1_retire && !in_accept, !s1_valid_q)

endmodule
